// ===== sv/cmas_pkg.sv =====
// Shared types and constants for the counting machine auto sequencer.
// Used by the front, queue, back, top level and checker; depends on nothing.
`default_nettype none

package cmas_pkg;

    // Event codes on the input tuser field.
    localparam logic [2:0] OP_START = 3'd0;
    localparam logic [2:0] OP_TIMER = 3'd1;
    localparam logic [2:0] OP_COUNT = 3'd2;
    localparam logic [2:0] OP_CAM   = 3'd3;
    localparam logic [2:0] OP_RESET = 3'd4;

    // Configuration register indexes (byte address / 4).
    localparam logic [2:0] REG_STAMP_ENABLE      = 3'd0;
    localparam logic [2:0] REG_ACCUMULATE_TARGET = 3'd1;
    localparam logic [2:0] REG_CAM_TIMEOUT       = 3'd2;
    localparam logic [2:0] REG_FREE_RUN          = 3'd3;
    localparam logic [2:0] REG_BATCH_COIL        = 3'd4;
    localparam logic [2:0] REG_STAMP_COIL        = 3'd5;
    localparam logic [2:0] REG_LONG_PAUSE        = 3'd6;
    localparam logic [2:0] REG_BEEP_TOTAL        = 3'd7;

    // Actuator bits.
    localparam logic [6:0] ACT_HOPPER = 7'h01;
    localparam logic [6:0] ACT_FEED   = 7'h02;
    localparam logic [6:0] ACT_PUMP   = 7'h04;
    localparam logic [6:0] ACT_BATCH  = 7'h08;
    localparam logic [6:0] ACT_STAMP  = 7'h10;
    localparam logic [6:0] ACT_BUZZ   = 7'h20;
    localparam logic [6:0] ACT_SENSOR = 7'h40;

    localparam logic [15:0] COUNT_STEP  = 16'd100;
    localparam logic [6:0]  REM_LAST    = 7'd99;
    localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
    localparam logic [19:0] TICK_MS     = 20'd1000;
    localparam logic [19:0] BEEP_ON_MS  = 20'd300;
    localparam logic [19:0] BEEP_OFF_MS = 20'd700;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 72;

    typedef enum logic [2:0] {
        PH_HOPPER = 3'd0,
        PH_FEED   = 3'd1,
        PH_BATCH  = 3'd2,
        PH_RETURN = 3'd3,
        PH_STAMP  = 3'd4,
        PH_DELAY  = 3'd5,
        PH_BEEP   = 3'd6,
        PH_ERROR  = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        EV_START,
        EV_TIMER,
        EV_COUNT,
        EV_CAM,
        EV_RESET,
        EV_NONE
    } ev_kind_t;

    typedef struct packed {
        ev_kind_t    kind;
        logic        pressed;
        logic        sensor_hit;
        logic [31:0] now_ms;
    } event_t;

    typedef struct packed {
        logic        stamp_enable;
        logic [15:0] accumulate_target;
        logic [15:0] cam_timeout_ms;
        logic [15:0] free_run_ms;
        logic [15:0] batch_coil_ms;
        logic [15:0] stamp_coil_ms;
        logic [19:0] long_pause_ms;
        logic [15:0] beep_total_ms;
    } cfg_t;

    typedef struct packed {
        logic        finished;
        logic [15:0] complete_count;
        logic [15:0] accumulate_count;
        logic [19:0] timer_ms;
        logic        timer_load;
        logic        sensor_clear;
        logic [6:0]  actuators;
        logic [2:0]  phase;
    } out_payload_t;

    localparam int OUT_PAYLOAD_W = $bits(out_payload_t);

endpackage

`default_nettype wire

// ===== sv/counter_machine_auto_sequencer_top.sv =====
// A request passes through the event queue, then the output register (m_tvalid).
// Throughput: one request per cycle while the output is not stalled by m_tready.
// A finished result waiting in the output register does not block new input requests
// until the event queue (QUEUE_DEPTH entries) is full.
// Reset (rst_n, asynchronous, active low) returns the phase, actuators and counters
// to zero, empties the event queue and loads the configuration registers' defaults.
`default_nettype none

// Top level of the counting machine auto sequencer. Depends on cmas_pkg,
// cmas_front, cmas_queue and cmas_back.
//
// The front end decodes each input request into an event and writes it to a
// short queue. The back end takes one event per cycle from the queue, unless a
// result waits for m_tready, runs the phase sequencer for it (event rule, entry
// step of the next phase, beep tick and a possible fall-through into the delay
// phase all in the same cycle) and loads the result into an output register.
// Because the queue and the output register decouple the two sides, the input
// keeps flowing while a result waits for m_tready, until the queue fills.
//
// The configuration registers sit on an APB-style port at byte addresses
// 0, 4, ... 28. They are meant to be written only while the block is idle.
module counter_machine_auto_sequencer_top #(
    parameter int QUEUE_DEPTH = 2    // events buffered between front and back, 2 to 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Input request channel.
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // [0] switch_pressed, [16:1] sensor_count, [48:17] now_ms, rest zero.
    input  wire logic [cmas_pkg::IN_TDATA_W-1:0]     s_tdata,
    // [2:0] opcode.
    input  wire logic [2:0]                          s_tuser,
    // Result channel.
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [2:0] phase, [9:3] actuators, [10] sensor_clear, [11] timer_load,
    // [31:12] timer_ms, [47:32] accumulate_count, [63:48] complete_count,
    // [64] finished, rest zero.
    output logic [cmas_pkg::OUT_TDATA_W-1:0]         m_tdata,
    // Configuration port.
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [4:0]                          paddr,
    input  wire logic [31:0]                         pwdata,
    output logic [31:0]                              prdata,
    output logic                                     pready
);

    cmas_pkg::cfg_t         cfg_reg;
    logic                   cfg_write;
    logic [2:0]             cfg_index;

    logic                   q_push;
    cmas_pkg::event_t       q_push_event;
    logic                   q_full;
    logic                   q_pop;
    logic                   q_valid;
    cmas_pkg::event_t       q_head;
    cmas_pkg::out_payload_t out_payload;

    // ---------------------------------------------------------------------
    // Configuration registers. The write lands at the access cycle's edge.
    // ---------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stamp_enable      <= 1'b0;
            cfg_reg.accumulate_target <= 16'd10000;
            cfg_reg.cam_timeout_ms    <= 16'd3000;
            cfg_reg.free_run_ms       <= 16'd5000;
            cfg_reg.batch_coil_ms     <= 16'd500;
            cfg_reg.stamp_coil_ms     <= 16'd500;
            cfg_reg.long_pause_ms     <= 20'd300000;
            cfg_reg.beep_total_ms     <= 16'd3000;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                cmas_pkg::REG_STAMP_ENABLE:      cfg_reg.stamp_enable      <= pwdata[0];
                cmas_pkg::REG_ACCUMULATE_TARGET: cfg_reg.accumulate_target <= pwdata[15:0];
                cmas_pkg::REG_CAM_TIMEOUT:       cfg_reg.cam_timeout_ms    <= pwdata[15:0];
                cmas_pkg::REG_FREE_RUN:          cfg_reg.free_run_ms       <= pwdata[15:0];
                cmas_pkg::REG_BATCH_COIL:        cfg_reg.batch_coil_ms     <= pwdata[15:0];
                cmas_pkg::REG_STAMP_COIL:        cfg_reg.stamp_coil_ms     <= pwdata[15:0];
                cmas_pkg::REG_LONG_PAUSE:        cfg_reg.long_pause_ms     <= pwdata[19:0];
                cmas_pkg::REG_BEEP_TOTAL:        cfg_reg.beep_total_ms     <= pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    // Read back, zero-extended to the bus width.
    always_comb
    begin
        case (cfg_index)
            cmas_pkg::REG_STAMP_ENABLE:      prdata = {31'd0, cfg_reg.stamp_enable};
            cmas_pkg::REG_ACCUMULATE_TARGET: prdata = {16'd0, cfg_reg.accumulate_target};
            cmas_pkg::REG_CAM_TIMEOUT:       prdata = {16'd0, cfg_reg.cam_timeout_ms};
            cmas_pkg::REG_FREE_RUN:          prdata = {16'd0, cfg_reg.free_run_ms};
            cmas_pkg::REG_BATCH_COIL:        prdata = {16'd0, cfg_reg.batch_coil_ms};
            cmas_pkg::REG_STAMP_COIL:        prdata = {16'd0, cfg_reg.stamp_coil_ms};
            cmas_pkg::REG_LONG_PAUSE:        prdata = {12'd0, cfg_reg.long_pause_ms};
            cmas_pkg::REG_BEEP_TOTAL:        prdata = {16'd0, cfg_reg.beep_total_ms};
            default:                         prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------
    // Front end: decode requests into events.
    // ---------------------------------------------------------------------
    cmas_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .q_full     (q_full),
        .push       (q_push),
        .push_event (q_push_event)
    );

    // ---------------------------------------------------------------------
    // Event queue.
    // ---------------------------------------------------------------------
    cmas_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_event (q_push_event),
        .full       (q_full),
        .pop        (q_pop),
        .valid      (q_valid),
        .head       (q_head)
    );

    // ---------------------------------------------------------------------
    // Back end: phase sequencer and output register.
    // ---------------------------------------------------------------------
    cmas_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_valid     (q_valid),
        .ev          (q_head),
        .pop         (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_payload (out_payload)
    );

    assign m_tdata = {{(cmas_pkg::OUT_TDATA_W - cmas_pkg::OUT_PAYLOAD_W){1'b0}}, out_payload};

endmodule

`default_nettype wire

// ===== sv/cmas_front.sv =====
// Front end: takes input requests and classifies them into events.
// Depends on cmas_pkg.
`default_nettype none

module cmas_front (
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [cmas_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  wire logic [2:0]                        s_tuser,
    input  wire logic                              q_full,
    output logic                                   push,
    output cmas_pkg::event_t                       push_event
);

    logic [15:0] sensor_count;

    assign s_tready     = !q_full;
    assign push         = s_tvalid && !q_full;
    assign sensor_count = s_tdata[16:1];

    always_comb
    begin
        push_event.pressed    = s_tdata[0];
        push_event.sensor_hit = (sensor_count >= cmas_pkg::COUNT_STEP);
        push_event.now_ms     = s_tdata[48:17];
        case (s_tuser)
            cmas_pkg::OP_START: push_event.kind = cmas_pkg::EV_START;
            cmas_pkg::OP_TIMER: push_event.kind = cmas_pkg::EV_TIMER;
            cmas_pkg::OP_COUNT: push_event.kind = cmas_pkg::EV_COUNT;
            cmas_pkg::OP_CAM:   push_event.kind = cmas_pkg::EV_CAM;
            cmas_pkg::OP_RESET: push_event.kind = cmas_pkg::EV_RESET;
            default:            push_event.kind = cmas_pkg::EV_NONE;
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/cmas_queue.sv =====
// Small event queue between the front end and the sequencer back end.
// Depends on cmas_pkg.
`default_nettype none

module cmas_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire cmas_pkg::event_t push_event,
    output logic                  full,
    input  wire logic             pop,
    output logic                  valid,
    output cmas_pkg::event_t      head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmas_pkg::event_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign valid = (count_reg != '0);
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_event;
        end
    end

endmodule

`default_nettype wire

// ===== sv/cmas_back.sv =====
// Back end: the phase sequencer, its counters and the output register.
// Depends on cmas_pkg.
`default_nettype none

module cmas_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire cmas_pkg::cfg_t         cfg,
    input  wire logic                   q_valid,
    input  wire cmas_pkg::event_t       ev,
    output logic                        pop,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output cmas_pkg::out_payload_t      out_payload
);

    cmas_pkg::phase_t phase_reg, phase_next;
    logic [6:0]  act_reg, act_next;
    logic [15:0] acc_reg, acc_next;
    logic [6:0]  acc_rem_reg, acc_rem_next;
    logic [15:0] comp_reg, comp_next;
    logic [19:0] pause_reg, pause_next;
    logic        beep_on_reg, beep_on_next;
    logic [31:0] beep_start_reg, beep_start_next;
    logic        out_valid_reg, out_valid_next;
    cmas_pkg::out_payload_t out_reg, out_next;

    // Per-item responses that are not state.
    logic        rsp_clear;
    logic        rsp_load;
    logic [19:0] rsp_timer;
    logic        rsp_fin;

    assign pop         = q_valid && (!out_valid_reg || out_ready);
    assign out_valid   = out_valid_reg;
    assign out_payload = out_reg;

    // Next state: event handling, then the entry step of a new phase, then
    // the beep tick, then the entry of the delay phase that the tick or an
    // event may ask for.
    always_comb
    begin
        logic             ent_v;
        cmas_pkg::phase_t ent_ph;
        logic             ent_delay;
        logic             tick;
        logic [31:0]      diff;
        logic [31:0]      mag;

        phase_next      = phase_reg;
        act_next        = act_reg;
        acc_next        = acc_reg;
        acc_rem_next    = acc_rem_reg;
        comp_next       = comp_reg;
        pause_next      = pause_reg;
        beep_on_next    = beep_on_reg;
        beep_start_next = beep_start_reg;
        rsp_clear       = 1'b0;
        rsp_load        = 1'b0;
        rsp_timer       = '0;
        rsp_fin         = 1'b0;
        ent_v           = 1'b0;
        ent_ph          = cmas_pkg::PH_HOPPER;
        ent_delay       = 1'b0;
        tick            = 1'b0;

        case (ev.kind)
            cmas_pkg::EV_START:
            begin
                ent_v  = 1'b1;
                ent_ph = cmas_pkg::PH_HOPPER;
            end
            cmas_pkg::EV_NONE:
            begin
            end
            default:
            begin
                case (phase_reg)
                    cmas_pkg::PH_HOPPER:
                    begin
                        if (ev.kind == cmas_pkg::EV_TIMER)
                        begin
                            act_next = act_next & ~(cmas_pkg::ACT_HOPPER | cmas_pkg::ACT_PUMP);
                            ent_v    = 1'b1;
                            ent_ph   = cmas_pkg::PH_ERROR;
                        end
                        else if (ev.kind == cmas_pkg::EV_CAM && !ev.pressed)
                        begin
                            act_next  = act_next & ~cmas_pkg::ACT_HOPPER;
                            rsp_load  = 1'b1;
                            rsp_timer = '0;
                            ent_v     = 1'b1;
                            ent_ph    = cmas_pkg::PH_FEED;
                        end
                        else if (ev.kind == cmas_pkg::EV_RESET && ev.pressed)
                        begin
                            act_next  = act_next & ~(cmas_pkg::ACT_HOPPER | cmas_pkg::ACT_PUMP);
                            rsp_load  = 1'b1;
                            rsp_timer = '0;
                            ent_v     = 1'b1;
                            ent_ph    = cmas_pkg::PH_RETURN;
                        end
                    end
                    cmas_pkg::PH_FEED:
                    begin
                        if (ev.kind == cmas_pkg::EV_COUNT)
                        begin
                            if (acc_next != cmas_pkg::COUNT_MAX)
                            begin
                                acc_next     = acc_next + 16'd1;
                                acc_rem_next = (acc_rem_next == cmas_pkg::REM_LAST) ?
                                               7'd0 : acc_rem_next + 7'd1;
                            end
                            if (ev.sensor_hit)
                            begin
                                // Round the count down to a whole step of 100.
                                acc_next     = acc_next - {9'd0, acc_rem_next};
                                acc_rem_next = 7'd0;
                                rsp_load     = 1'b1;
                                rsp_timer    = '0;
                                act_next     = act_next & ~(cmas_pkg::ACT_FEED |
                                               cmas_pkg::ACT_PUMP | cmas_pkg::ACT_SENSOR);
                                ent_v        = 1'b1;
                                ent_ph       = cmas_pkg::PH_BATCH;
                            end
                        end
                        else if (ev.kind == cmas_pkg::EV_TIMER)
                        begin
                            act_next = act_next & ~(cmas_pkg::ACT_FEED |
                                       cmas_pkg::ACT_PUMP | cmas_pkg::ACT_SENSOR);
                            ent_v    = 1'b1;
                            ent_ph   = cmas_pkg::PH_BATCH;
                        end
                        else if (ev.kind == cmas_pkg::EV_RESET && ev.pressed)
                        begin
                            act_next  = act_next & ~(cmas_pkg::ACT_FEED |
                                        cmas_pkg::ACT_PUMP | cmas_pkg::ACT_SENSOR);
                            rsp_load  = 1'b1;
                            rsp_timer = '0;
                            ent_v     = 1'b1;
                            ent_ph    = cmas_pkg::PH_RETURN;
                        end
                    end
                    cmas_pkg::PH_BATCH:
                    begin
                        if (ev.kind == cmas_pkg::EV_TIMER)
                        begin
                            act_next = act_next & ~cmas_pkg::ACT_BATCH;
                            ent_v    = 1'b1;
                            ent_ph   = cmas_pkg::PH_RETURN;
                        end
                    end
                    cmas_pkg::PH_RETURN:
                    begin
                        if (ev.kind == cmas_pkg::EV_TIMER)
                        begin
                            act_next = act_next & ~cmas_pkg::ACT_HOPPER;
                            ent_v    = 1'b1;
                            ent_ph   = cmas_pkg::PH_ERROR;
                        end
                        else if (ev.kind == cmas_pkg::EV_CAM && ev.pressed)
                        begin
                            act_next  = act_next & ~cmas_pkg::ACT_HOPPER;
                            rsp_load  = 1'b1;
                            rsp_timer = '0;
                            ent_v     = 1'b1;
                            ent_ph    = cmas_pkg::PH_STAMP;
                        end
                    end
                    cmas_pkg::PH_STAMP:
                    begin
                        if (ev.kind == cmas_pkg::EV_TIMER)
                        begin
                            ent_v  = 1'b1;
                            ent_ph = cmas_pkg::PH_DELAY;
                            if (acc_reg >= cfg.accumulate_target)
                            begin
                                if (comp_next != cmas_pkg::COUNT_MAX)
                                begin
                                    comp_next = comp_next + 16'd1;
                                end
                                ent_ph = cmas_pkg::PH_BEEP;
                            end
                            if (cfg.stamp_enable)
                            begin
                                act_next = act_next & ~cmas_pkg::ACT_STAMP;
                            end
                        end
                    end
                    cmas_pkg::PH_DELAY:
                    begin
                        if (ev.kind == cmas_pkg::EV_TIMER)
                        begin
                            if (acc_reg >= cfg.accumulate_target)
                            begin
                                if (pause_reg <= cmas_pkg::TICK_MS)
                                begin
                                    pause_next   = '0;
                                    acc_next     = '0;
                                    acc_rem_next = 7'd0;
                                    ent_v        = 1'b1;
                                    ent_ph       = cmas_pkg::PH_HOPPER;
                                end
                                else
                                begin
                                    pause_next = pause_reg - cmas_pkg::TICK_MS;
                                    rsp_load   = 1'b1;
                                    rsp_timer  = cmas_pkg::TICK_MS;
                                end
                            end
                            else
                            begin
                                ent_v  = 1'b1;
                                ent_ph = cmas_pkg::PH_HOPPER;
                            end
                        end
                        else if (ev.kind == cmas_pkg::EV_RESET && ev.pressed)
                        begin
                            rsp_load     = 1'b1;
                            rsp_timer    = '0;
                            acc_next     = '0;
                            acc_rem_next = 7'd0;
                            comp_next    = '0;
                            rsp_clear    = 1'b1;
                            rsp_fin      = 1'b1;
                        end
                    end
                    cmas_pkg::PH_BEEP:
                    begin
                        if (ev.kind == cmas_pkg::EV_TIMER)
                        begin
                            tick = 1'b1;
                        end
                        else if (ev.kind == cmas_pkg::EV_RESET && ev.pressed)
                        begin
                            beep_on_next = 1'b0;
                            act_next     = act_next & ~cmas_pkg::ACT_BUZZ;
                            rsp_load     = 1'b1;
                            rsp_timer    = '0;
                            ent_delay    = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        endcase

        // Entry step of the new phase.
        if (ent_v)
        begin
            phase_next = ent_ph;
            case (ent_ph)
                cmas_pkg::PH_HOPPER:
                begin
                    rsp_clear = 1'b1;
                    act_next  = act_next | cmas_pkg::ACT_HOPPER | cmas_pkg::ACT_PUMP;
                    rsp_load  = 1'b1;
                    rsp_timer = {4'd0, cfg.cam_timeout_ms};
                end
                cmas_pkg::PH_FEED:
                begin
                    act_next  = act_next | cmas_pkg::ACT_SENSOR | cmas_pkg::ACT_FEED |
                                cmas_pkg::ACT_PUMP;
                    rsp_load  = 1'b1;
                    rsp_timer = {4'd0, cfg.free_run_ms};
                end
                cmas_pkg::PH_BATCH:
                begin
                    act_next  = act_next | cmas_pkg::ACT_BATCH;
                    rsp_load  = 1'b1;
                    rsp_timer = {4'd0, cfg.batch_coil_ms};
                end
                cmas_pkg::PH_RETURN:
                begin
                    act_next  = act_next | cmas_pkg::ACT_HOPPER;
                    rsp_load  = 1'b1;
                    rsp_timer = {4'd0, cfg.cam_timeout_ms};
                end
                cmas_pkg::PH_STAMP:
                begin
                    if (cfg.stamp_enable)
                    begin
                        act_next = act_next | cmas_pkg::ACT_STAMP;
                    end
                    rsp_load  = 1'b1;
                    rsp_timer = {4'd0, cfg.stamp_coil_ms};
                end
                cmas_pkg::PH_DELAY:
                begin
                    ent_delay = 1'b1;
                end
                cmas_pkg::PH_BEEP:
                begin
                    beep_start_next = ev.now_ms;
                    tick            = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        // Beep tick: elapsed time is the magnitude of the signed difference.
        diff = ev.now_ms - beep_start_next;
        mag  = diff[31] ? (32'd0 - diff) : diff;
        if (tick)
        begin
            if (mag >= {16'd0, cfg.beep_total_ms})
            begin
                beep_on_next = 1'b0;
                act_next     = act_next & ~cmas_pkg::ACT_BUZZ;
                rsp_load     = 1'b1;
                rsp_timer    = '0;
                ent_delay    = 1'b1;
            end
            else if (beep_on_next)
            begin
                beep_on_next = 1'b0;
                act_next     = act_next & ~cmas_pkg::ACT_BUZZ;
                rsp_load     = 1'b1;
                rsp_timer    = cmas_pkg::BEEP_OFF_MS;
            end
            else
            begin
                beep_on_next = 1'b1;
                act_next     = act_next | cmas_pkg::ACT_BUZZ;
                rsp_load     = 1'b1;
                rsp_timer    = cmas_pkg::BEEP_ON_MS;
            end
        end

        // Entry of the delay phase.
        if (ent_delay)
        begin
            phase_next = cmas_pkg::PH_DELAY;
            rsp_load   = 1'b1;
            rsp_timer  = cmas_pkg::TICK_MS;
            pause_next = cfg.long_pause_ms;
        end
    end

    // Outputs: the result item built from the updated state.
    always_comb
    begin
        out_next.phase            = phase_next;
        out_next.actuators        = act_next;
        out_next.sensor_clear     = rsp_clear;
        out_next.timer_load       = rsp_load;
        out_next.timer_ms         = rsp_timer;
        out_next.accumulate_count = acc_next;
        out_next.complete_count   = comp_next;
        out_next.finished         = rsp_fin;

        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= cmas_pkg::PH_HOPPER;
            act_reg        <= '0;
            acc_reg        <= '0;
            acc_rem_reg    <= '0;
            comp_reg       <= '0;
            pause_reg      <= '0;
            beep_on_reg    <= 1'b0;
            beep_start_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                phase_reg      <= phase_next;
                act_reg        <= act_next;
                acc_reg        <= acc_next;
                acc_rem_reg    <= acc_rem_next;
                comp_reg       <= comp_next;
                pause_reg      <= pause_next;
                beep_on_reg    <= beep_on_next;
                beep_start_reg <= beep_start_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/cmas_checker.sv =====
// Port-level checks for the counting machine auto sequencer, with its bind.
// Depends on cmas_pkg and counter_machine_auto_sequencer_top.
`default_nettype none

module cmas_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [cmas_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    cmas_pkg::out_payload_t res;

    assign res = cmas_pkg::out_payload_t'(m_tdata[cmas_pkg::OUT_PAYLOAD_W-1:0]);

    // A result that is not taken stays put.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A finishing reset clears both counters and leaves the block in the delay phase.
    a_finish: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.finished |->
            res.phase == cmas_pkg::PH_DELAY && res.accumulate_count == 16'd0 &&
            res.complete_count == 16'd0 && res.sensor_clear)
        else $error("finished result with wrong state");

    // No timer value without a timer load.
    a_timer: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !res.timer_load |-> res.timer_ms == 20'd0)
        else $error("timer value without load");

    // A sensor clear comes only from hopper entry or a finishing reset.
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.sensor_clear |->
            res.phase == cmas_pkg::PH_HOPPER || res.finished)
        else $error("unexpected sensor clear");

endmodule

bind counter_machine_auto_sequencer_top cmas_checker u_cmas_checker (.*);

`default_nettype wire
